// ----- rtl/core/pdsc_pkg.sv -----
// shared constants, verdict codes and the queue entry type for the packet deframer core
// no dependencies

package pdsc_pkg;

  // frame layout
  localparam logic [7:0] MAX_PAYLOAD = 8'd200;
  localparam logic [8:0] HDR_LEN     = 9'd5;
  localparam logic [8:0] MIN_PACKET  = 9'd7;
  localparam logic [8:0] POS_MAX     = 9'd511;
  localparam int         HDR_IDX_W   = 3;

  // rssi handling
  localparam logic [7:0]  RSSI_FLOOR  = 8'd164;
  // divide by ten as multiply by ceil(2^16/10) and shift, exact for x below 2^14
  localparam logic [12:0] RECIP_10    = 13'd6554;
  localparam int          RECIP_SHIFT = 16;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // verdict codes
  localparam logic [2:0] VERDICT_OK        = 3'd0;
  localparam logic [2:0] VERDICT_SHORT     = 3'd1;
  localparam logic [2:0] VERDICT_LEN_LIMIT = 3'd2;
  localparam logic [2:0] VERDICT_TRUNC     = 3'd3;
  localparam logic [2:0] VERDICT_CHECKSUM  = 3'd4;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // one classified beat waiting for the back end
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] msg_type;
    logic [7:0] source_node;
    logic [7:0] dest_node;
    logic [7:0] seq_number;
    logic [7:0] payload_count;
    logic [2:0] verdict;
    logic [7:0] rssi_mag;
  } entry_t;

endpackage

// ----- rtl/core/packet_deframer_sum_checksum_core.sv -----
// top level of the packet deframer with 16-bit additive checksum
// depends on pdsc_pkg, pdsc_front, pdsc_fifo and pdsc_back

// Receives a packet one byte per beat: five header bytes (type, source, destination,
// sequence, payload length), the payload, and a big-endian 16-bit wrapping sum of all
// header and payload bytes. Each payload byte leaves as a tuser=0 beat with its index;
// the byte marked with tlast leaves as a tuser=1 verdict beat carrying the header, the
// verdict (ok, too short, length over limit, truncated, checksum mismatch), the good
// packet count and the rssi moving average avg=(avg*9+rssi)/10. Payload bytes past the
// declared length (capped at 200) and the checksum give no beat, nor do trailing bytes.
// Downstream drops the payload of a packet whose verdict is not ok. One input beat is
// taken per cycle while the queue has room; a result is classified by the front end in
// the accepting cycle, waits in the queue and is registered in the back end's output.
// A two-entry queue between front and back keeps the input open while the output
// register waits on tready; input tready drops only while that queue is full.

module packet_deframer_sum_checksum_core import pdsc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input beats
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,  // rx_byte [7:0], packet_rssi [16:8], zero [23:17]
  input  logic         s_axis_tlast,  // end_of_packet
  // result beats
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // payload_byte [7:0], payload_index [15:8], msg_type [23:16], source_node [31:24],
  // dest_node [39:32], seq_number [47:40], payload_count [55:48], verdict [58:56],
  // good_packets [90:59], rssi_average [99:91], zero [103:100]
  output logic [103:0] m_axis_tdata,
  output logic         m_axis_tuser   // kind
);

  logic   accept;
  logic   push;
  logic   full;
  logic   empty;
  logic   pop;
  entry_t wr_entry;
  entry_t rd_entry;

  logic        kind;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [7:0]  msg_type;
  logic [7:0]  source_node;
  logic [7:0]  dest_node;
  logic [7:0]  seq_number;
  logic [7:0]  payload_count;
  logic [2:0]  verdict;
  logic [31:0] good_packets;
  logic [8:0]  rssi_average;

  // queue room is the only thing that holds the input back
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  pdsc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .rx_byte_i       (s_axis_tdata[7:0]),
    .end_of_packet_i (s_axis_tlast),
    .packet_rssi_i   (s_axis_tdata[16:8]),
    .push_o          (push),
    .entry_o         (wr_entry)
  );

  pdsc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_entry),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (rd_entry),
    .empty_o (empty)
  );

  pdsc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entry_i         (rd_entry),
    .empty_i         (empty),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .kind_o          (kind),
    .payload_byte_o  (payload_byte),
    .payload_index_o (payload_index),
    .msg_type_o      (msg_type),
    .source_node_o   (source_node),
    .dest_node_o     (dest_node),
    .seq_number_o    (seq_number),
    .payload_count_o (payload_count),
    .verdict_o       (verdict),
    .good_packets_o  (good_packets),
    .rssi_average_o  (rssi_average)
  );

  // pack the result beat, first field in the lowest bits
  assign m_axis_tuser = kind;
  assign m_axis_tdata = {4'd0, rssi_average, good_packets, verdict, payload_count,
                         seq_number, dest_node, source_node, msg_type,
                         payload_index, payload_byte};

endmodule

// ----- rtl/core/pdsc_front.sv -----
// front end: tracks the frame position, header, running sum and checksum bytes
// and turns each payload or end-of-packet beat into a queue entry; depends on pdsc_pkg

module pdsc_front import pdsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  logic       end_of_packet_i,
  input  logic [8:0] packet_rssi_i,
  output logic       push_o,
  output entry_t     entry_o
);

  logic [8:0]  pos_q, pos_d;
  logic [7:0]  hdr_q [HDR_LEN];
  logic [7:0]  hdr_d [HDR_LEN];
  logic [15:0] sum_q, sum_d;
  logic [7:0]  chk_hi_q, chk_hi_d;
  logic [7:0]  chk_lo_q, chk_lo_d;

  logic [7:0] len_eff;
  logic [8:0] offset;
  logic       in_hdr;
  logic       in_payload;
  logic [2:0] verdict;
  logic [9:0] rssi_neg;
  logic [7:0] rssi_mag;

  always_comb begin
    len_eff    = (hdr_q[4] > MAX_PAYLOAD) ? MAX_PAYLOAD : hdr_q[4];
    offset     = pos_q - HDR_LEN;
    in_hdr     = pos_q < HDR_LEN;
    in_payload = !in_hdr && (offset < {1'b0, len_eff});

    hdr_d    = hdr_q;
    sum_d    = sum_q;
    chk_hi_d = chk_hi_q;
    chk_lo_d = chk_lo_q;
    if (in_hdr) begin
      hdr_d[pos_q[HDR_IDX_W-1:0]] = rx_byte_i;
      sum_d = sum_q + {8'd0, rx_byte_i};
    end else if (in_payload) begin
      sum_d = sum_q + {8'd0, rx_byte_i};
    end else if (pos_q == HDR_LEN + {1'b0, len_eff}) begin
      chk_hi_d = rx_byte_i;
    end else if (pos_q == HDR_LEN + {1'b0, len_eff} + 9'd1) begin
      chk_lo_d = rx_byte_i;
    end
    pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + 9'd1;

    // verdict priority: short, over limit, truncated, checksum
    if (pos_d < MIN_PACKET) begin
      verdict = VERDICT_SHORT;
    end else if (hdr_d[4] > MAX_PAYLOAD) begin
      verdict = VERDICT_LEN_LIMIT;
    end else if (pos_d < MIN_PACKET + {1'b0, hdr_d[4]}) begin
      verdict = VERDICT_TRUNC;
    end else if (sum_d != {chk_hi_d, chk_lo_d}) begin
      verdict = VERDICT_CHECKSUM;
    end else begin
      verdict = VERDICT_OK;
    end

    // magnitude of a negative rssi, clamped to the floor
    rssi_neg = 10'd512 - {1'b0, packet_rssi_i};
    if (!packet_rssi_i[8]) begin
      rssi_mag = 8'd0;
    end else if (rssi_neg > {2'b0, RSSI_FLOOR}) begin
      rssi_mag = RSSI_FLOOR;
    end else begin
      rssi_mag = rssi_neg[7:0];
    end

    entry_o = '0;
    if (end_of_packet_i) begin
      entry_o.kind          = KIND_VERDICT;
      entry_o.msg_type      = hdr_d[0];
      entry_o.source_node   = hdr_d[1];
      entry_o.dest_node     = hdr_d[2];
      entry_o.seq_number    = hdr_d[3];
      entry_o.payload_count = hdr_d[4];
      entry_o.verdict       = verdict;
      entry_o.rssi_mag      = rssi_mag;
    end else begin
      entry_o.kind          = KIND_PAYLOAD;
      entry_o.payload_byte  = rx_byte_i;
      entry_o.payload_index = offset[7:0];
    end
    push_o = accept_i && (end_of_packet_i || in_payload);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      sum_q    <= '0;
      chk_hi_q <= '0;
      chk_lo_q <= '0;
      for (int i = 0; i < HDR_LEN; i++) begin
        hdr_q[i] <= '0;
      end
    end else if (accept_i) begin
      if (end_of_packet_i) begin
        pos_q    <= '0;
        sum_q    <= '0;
        chk_hi_q <= '0;
        chk_lo_q <= '0;
        for (int i = 0; i < HDR_LEN; i++) begin
          hdr_q[i] <= '0;
        end
      end else begin
        pos_q    <= pos_d;
        sum_q    <= sum_d;
        chk_hi_q <= chk_hi_d;
        chk_lo_q <= chk_lo_d;
        hdr_q    <= hdr_d;
      end
    end
  end

endmodule

// ----- rtl/core/pdsc_fifo.sv -----
// two-entry queue between the front and back ends
// depends on pdsc_pkg for the entry type and depth

module pdsc_fifo import pdsc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t wdata_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t rdata_o,
  output logic   empty_o
);

  entry_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q;
  logic [Q_PTR_W-1:0] rd_ptr_q;
  logic [Q_CNT_W-1:0] count_q;

  assign full_o  = (count_q == Q_CNT_W'(Q_DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count out of range");

endmodule

// ----- rtl/core/pdsc_back.sv -----
// back end: keeps the good-packet count and rssi average, fills the output register
// depends on pdsc_pkg

module pdsc_back import pdsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  entry_t      entry_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  payload_index_o,
  output logic [7:0]  msg_type_o,
  output logic [7:0]  source_node_o,
  output logic [7:0]  dest_node_o,
  output logic [7:0]  seq_number_o,
  output logic [7:0]  payload_count_o,
  output logic [2:0]  verdict_o,
  output logic [31:0] good_packets_o,
  output logic [8:0]  rssi_average_o
);

  logic        valid_q;
  logic [31:0] good_q, good_d;
  logic [7:0]  mean_q, mean_d;
  entry_t      ent_q;

  logic        is_ok;
  logic [11:0] acc;
  logic [24:0] prod;

  always_comb begin
    pop_o  = !empty_i && (!valid_q || out_ready_i);
    is_ok  = (entry_i.kind == KIND_VERDICT) && (entry_i.verdict == VERDICT_OK);
    // mean*9 + magnitude, then divide by ten
    acc    = ({4'd0, mean_q} << 3) + {4'd0, mean_q} + {4'd0, entry_i.rssi_mag};
    prod   = {13'd0, acc} * {12'd0, RECIP_10};
    good_d = good_q;
    mean_d = mean_q;
    if (pop_o && is_ok) begin
      good_d = good_q + 32'd1;
      mean_d = prod[RECIP_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      good_q  <= '0;
      mean_q  <= '0;
    end else begin
      good_q <= good_d;
      mean_q <= mean_d;
      if (pop_o) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= entry_i;
    end
  end

  // count and average are shown only with verdicts
  always_comb begin
    out_valid_o     = valid_q;
    kind_o          = ent_q.kind;
    payload_byte_o  = ent_q.payload_byte;
    payload_index_o = ent_q.payload_index;
    msg_type_o      = ent_q.msg_type;
    source_node_o   = ent_q.source_node;
    dest_node_o     = ent_q.dest_node;
    seq_number_o    = ent_q.seq_number;
    payload_count_o = ent_q.payload_count;
    verdict_o       = ent_q.verdict;
    good_packets_o  = (ent_q.kind == KIND_VERDICT) ? good_q : '0;
    rssi_average_o  = (ent_q.kind == KIND_VERDICT) ? 9'(9'd0 - {1'b0, mean_q}) : '0;
  end

  a_good_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && is_ok) |=> (good_q == $past(good_q) + 32'd1))
    else $error("good packet count did not step on an ok verdict");

  a_good_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_o && is_ok) |=> $stable(good_q) && $stable(mean_q))
    else $error("packet statistics changed without an ok verdict");

  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mean_q <= RSSI_FLOOR)
    else $error("rssi average beyond the floor");

endmodule
